### rtl/deq_pkg.sv
// Shared types and request/status codes for the double-ended queue.
`timescale 1ns / 1ps

package deq_pkg;

    typedef logic [2:0] t_req_type;
    typedef logic [1:0] t_status;
    typedef logic [3:0] t_position;
    typedef logic [4:0] t_occupancy;
    typedef logic signed [31:0] t_value;

    localparam t_req_type REQ_PUSH_FRONT = 3'd0;
    localparam t_req_type REQ_PUSH_BACK  = 3'd1;
    localparam t_req_type REQ_POP_FRONT  = 3'd2;
    localparam t_req_type REQ_POP_BACK   = 3'd3;
    localparam t_req_type REQ_REMOVE     = 3'd4;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_EMPTY   = 2'd1;
    localparam t_status ST_NOINDEX = 2'd2;
    localparam t_status ST_FULL    = 2'd3;

endpackage

### rtl/deque_with_indexed_removal.sv
// Top level: bounded double-ended queue with removal by position.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_req_type, i_push_value, i_position
//  out     | output    | o_out_valid / i_out_ready  | o_status, o_removed_value, o_occupancy
//
// One item at a time. A middle removal shifts every later entry down by one position,
// one store write per moved entry through the single RAM write port.
// Reset clears the front slot, the count and the handshake state; the store is not cleared.
// A finished result waits in the output register; a new item is taken while it waits.
`timescale 1ns / 1ps

module deque_with_indexed_removal #(
    parameter int QUEUE_DEPTH = 16,
    parameter int VALUE_BITS  = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  deq_pkg::t_req_type     i_req_type,
    input  deq_pkg::t_value        i_push_value,
    input  deq_pkg::t_position     i_position,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output deq_pkg::t_status       o_status,
    output deq_pkg::t_value        o_removed_value,
    output deq_pkg::t_occupancy    o_occupancy
);

    import deq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int PW = (CW > 4) ? CW : 4;
    localparam int SW = ((AW > CW) ? AW : CW) + 1;
    localparam int XW = (VALUE_BITS > 32) ? VALUE_BITS : 32;

    typedef enum logic [2:0] {S_IDLE, S_EXEC, S_READ, S_SHIFT, S_DONE} t_state;

    t_state                r_state;
    t_req_type             r_kind;
    logic [VALUE_BITS-1:0] r_val;
    t_position             r_pos;
    logic [AW-1:0]         r_front;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_idx;
    logic                  r_from_front;
    logic                  r_mid;
    t_status               r_res_status;
    t_value                r_taken;

    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [VALUE_BITS-1:0] w_wdata;
    logic                  w_re;
    logic [AW-1:0]         w_raddr;
    logic [VALUE_BITS-1:0] w_rdata;

    logic [XW-1:0]         w_push_ext;
    logic [XW-1:0]         w_rd_ext;
    logic                  w_empty;
    logic                  w_full;
    logic                  w_noindex;
    logic                  w_pos_first;
    logic                  w_pos_last;
    logic [AW-1:0]         w_front_dec;
    logic [AW-1:0]         w_front_inc;
    logic                  w_more;

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] front,
                                              input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(front) + SW'(off);
        if (sum >= SW'(QUEUE_DEPTH)) begin
            sum = sum - SW'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_push_ext  = XW'($unsigned(i_push_value));
    assign w_rd_ext    = XW'(w_rdata);
    assign w_empty     = (r_count == '0);
    assign w_full      = (r_count == CW'(QUEUE_DEPTH));
    assign w_noindex   = (PW'(r_pos) >= PW'(r_count));
    assign w_pos_first = (r_pos == '0);
    assign w_pos_last  = (PW'(r_pos) == PW'(r_count) - PW'(1));
    assign w_front_dec = (r_front == '0) ? AW'(QUEUE_DEPTH - 1) : r_front - AW'(1);
    assign w_front_inc = (r_front == AW'(QUEUE_DEPTH - 1)) ? '0 : r_front + AW'(1);
    assign w_more      = ((CW + 1)'(r_idx) + (CW + 1)'(2)) < (CW + 1)'(r_count);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_front;
        w_wdata = r_val;
        w_re    = 1'b0;
        w_raddr = r_front;
        case (r_state)
            S_EXEC: begin
                case (r_kind)
                    REQ_PUSH_FRONT: begin
                        w_we    = !w_full;
                        w_waddr = w_front_dec;
                    end
                    REQ_PUSH_BACK: begin
                        w_we    = !w_full;
                        w_waddr = slot_of(r_front, r_count);
                    end
                    REQ_POP_FRONT: begin
                        w_re = !w_empty;
                    end
                    REQ_POP_BACK: begin
                        w_re    = !w_empty;
                        w_raddr = slot_of(r_front, r_count - CW'(1));
                    end
                    REQ_REMOVE: begin
                        w_re    = !w_empty && !w_noindex;
                        w_raddr = slot_of(r_front, CW'(r_pos));
                    end
                    default: begin
                    end
                endcase
            end
            S_READ: begin
                w_re    = r_mid;
                w_raddr = slot_of(r_front, CW'(r_pos) + CW'(1));
            end
            S_SHIFT: begin
                w_we    = 1'b1;
                w_waddr = slot_of(r_front, r_idx);
                w_wdata = w_rdata;
                w_re    = w_more;
                w_raddr = slot_of(r_front, r_idx + CW'(2));
            end
            default: begin
            end
        endcase
    end

    deq_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready && r_state != S_DONE) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_kind  <= i_req_type;
                        r_val   <= w_push_ext[VALUE_BITS-1:0];
                        r_pos   <= i_position;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_taken      <= '0;
                    r_from_front <= (r_kind == REQ_POP_FRONT) ||
                                    ((r_kind == REQ_REMOVE) && w_pos_first);
                    r_mid        <= (r_kind == REQ_REMOVE) && !w_pos_first && !w_pos_last;
                    case (r_kind)
                        REQ_PUSH_FRONT: begin
                            r_state <= S_DONE;
                            if (w_full) begin
                                r_res_status <= ST_FULL;
                            end else begin
                                r_res_status <= ST_OK;
                                r_front      <= w_front_dec;
                                r_count      <= r_count + CW'(1);
                            end
                        end
                        REQ_PUSH_BACK: begin
                            r_state <= S_DONE;
                            if (w_full) begin
                                r_res_status <= ST_FULL;
                            end else begin
                                r_res_status <= ST_OK;
                                r_count      <= r_count + CW'(1);
                            end
                        end
                        REQ_POP_FRONT, REQ_POP_BACK: begin
                            if (w_empty) begin
                                r_res_status <= ST_EMPTY;
                                r_state      <= S_DONE;
                            end else begin
                                r_res_status <= ST_OK;
                                r_state      <= S_READ;
                            end
                        end
                        REQ_REMOVE: begin
                            if (w_empty) begin
                                r_res_status <= ST_EMPTY;
                                r_state      <= S_DONE;
                            end else if (w_noindex) begin
                                r_res_status <= ST_NOINDEX;
                                r_state      <= S_DONE;
                            end else begin
                                r_res_status <= ST_OK;
                                r_state      <= S_READ;
                            end
                        end
                        default: begin
                            r_res_status <= ST_OK;
                            r_state      <= S_DONE;
                        end
                    endcase
                end
                S_READ: begin
                    r_taken <= w_rd_ext[31:0];
                    if (r_mid) begin
                        r_idx   <= CW'(r_pos);
                        r_state <= S_SHIFT;
                    end else begin
                        if (r_from_front) begin
                            r_front <= w_front_inc;
                        end
                        r_count <= r_count - CW'(1);
                        r_state <= S_DONE;
                    end
                end
                S_SHIFT: begin
                    if (w_more) begin
                        r_idx <= r_idx + CW'(1);
                    end else begin
                        r_count <= r_count - CW'(1);
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!o_out_valid || i_out_ready) begin
                        o_out_valid     <= 1'b1;
                        o_status        <= r_res_status;
                        o_removed_value <= r_taken;
                        o_occupancy     <= t_occupancy'(r_count);
                        r_state         <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("item accepted while another is in flight");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_EMPTY) |-> (o_occupancy == '0 && o_removed_value == '0))
        else $error("empty status with entries or a value");

    a_no_access_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && w_re) |-> (w_waddr != w_raddr))
        else $error("store read and write hit the same slot");
`endif

endmodule

### rtl/deq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

### sim/testbench.sv
// Testbench for the double-ended queue: directed and random requests checked against a predictor.
`timescale 1ns / 1ps

module testbench;
    import deq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int RANDOM_REQS = 1000;
    localparam int PHASE_LEN   = 40;
    localparam int MAX_GAP     = 14;
    localparam int CYCLE_LIMIT = 400000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_req_type  i_req_type;
    t_value     i_push_value;
    t_position  i_position;
    logic       o_out_valid;
    logic       i_out_ready;
    t_status    o_status;
    t_value     o_removed_value;
    t_occupancy o_occupancy;

    logic calm;
    int   cycles;

    class deque_scoreboard;
        typedef struct {
            t_status    status;
            t_value     removed;
            t_occupancy occ;
        } t_outcome;

        t_value     slots[DEPTH];
        t_position  head;
        t_occupancy count;
        t_outcome   outcome_q[$];
        int         errors;

        function new();
            head   = '0;
            count  = '0;
            errors = 0;
            foreach (slots[k]) slots[k] = '0;
        endfunction

        function int pending();
            return outcome_q.size();
        endfunction

        function t_position slot_at(int offset);
            return t_position'(head + offset);
        endfunction

        function void note_request(t_req_type kind, t_value value, t_position pos);
            t_outcome o;
            int i;
            o.status  = ST_OK;
            o.removed = '0;
            case (kind)
                REQ_PUSH_FRONT: begin
                    if (count >= DEPTH) begin
                        o.status = ST_FULL;
                    end else begin
                        head = head - 1'b1;
                        slots[head] = value;
                        count++;
                    end
                end
                REQ_PUSH_BACK: begin
                    if (count >= DEPTH) begin
                        o.status = ST_FULL;
                    end else begin
                        slots[slot_at(count)] = value;
                        count++;
                    end
                end
                REQ_POP_FRONT: begin
                    if (count == 0) begin
                        o.status = ST_EMPTY;
                    end else begin
                        o.removed = slots[head];
                        head = head + 1'b1;
                        count--;
                    end
                end
                REQ_POP_BACK: begin
                    if (count == 0) begin
                        o.status = ST_EMPTY;
                    end else begin
                        o.removed = slots[slot_at(count - 1)];
                        count--;
                    end
                end
                REQ_REMOVE: begin
                    if (count == 0) begin
                        o.status = ST_EMPTY;
                    end else if (pos >= count) begin
                        o.status = ST_NOINDEX;
                    end else if (pos == 0) begin
                        o.removed = slots[head];
                        head = head + 1'b1;
                        count--;
                    end else begin
                        o.removed = slots[slot_at(pos)];
                        for (i = pos; i + 1 < count; i++)
                            slots[slot_at(i)] = slots[slot_at(i + 1)];
                        count--;
                    end
                end
                default: begin
                end
            endcase
            o.occ = count;
            outcome_q.push_back(o);
        endfunction

        function void check_result(t_status status, t_value removed, t_occupancy occ);
            t_outcome o;
            if (outcome_q.size() == 0) begin
                $error("unexpected item: status %0d removed_value %0d occupancy %0d",
                       status, removed, occ);
                errors++;
                return;
            end
            o = outcome_q.pop_front();
            if (status !== o.status) begin
                $error("status: expected %0d, got %0d", o.status, status);
                errors++;
            end
            if (removed !== o.removed) begin
                $error("removed_value: expected %0d, got %0d", o.removed, removed);
                errors++;
            end
            if (occ !== o.occ) begin
                $error("occupancy: expected %0d, got %0d", o.occ, occ);
                errors++;
            end
        endfunction
    endclass

    deque_scoreboard sb;

    deque_with_indexed_removal uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_req_type      (i_req_type),
        .i_push_value    (i_push_value),
        .i_position      (i_position),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_removed_value (o_removed_value),
        .o_occupancy     (o_occupancy)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_status, o_removed_value, o_occupancy);
    end

    // Entered and left at a falling edge.
    task automatic send_request(t_req_type kind, t_value value, t_position pos);
        int gap;
        gap = calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   = 1'b1;
        i_req_type   = kind;
        i_push_value = value;
        i_position   = pos;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(kind, value, pos);
        @(negedge i_clk);
    endtask

    function automatic t_value pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return -32'sd1;
            3: return '0;
            default: return t_value'($urandom);
        endcase
    endfunction

    // Bias the mix: 0 fills, 1 drains, 2 balanced.
    task automatic send_random(int mood);
        int        roll;
        int        push_odds;
        t_req_type kind;
        t_position pos;
        roll      = $urandom_range(0, 99);
        push_odds = (mood == 0) ? 70 : (mood == 1) ? 25 : 50;
        if (roll < 4)
            kind = t_req_type'($urandom_range(5, 7));
        else if (roll < 4 + push_odds)
            kind = $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
        else if ($urandom_range(0, 2) == 0)
            kind = $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
        else
            kind = REQ_REMOVE;
        if (sb.count > 0 && $urandom_range(0, 99) < 85)
            pos = t_position'($urandom_range(0, sb.count - 1));
        else
            pos = t_position'($urandom_range(0, DEPTH - 1));
        send_request(kind, pick_value(), pos);
    endtask

    initial begin
        int stall;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                i_out_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    initial begin
        int n;
        int mood;
        sb           = new();
        calm         = 1'b0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_req_type   = REQ_PUSH_FRONT;
        i_push_value = '0;
        i_position   = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_request(REQ_POP_FRONT, 32'sd5, 4'd0);
        send_request(REQ_POP_BACK, 32'sd5, 4'd0);
        send_request(REQ_REMOVE, 32'sd5, 4'd0);
        send_request(REQ_PUSH_FRONT, 32'sh8000_0000, 4'd15);
        send_request(REQ_PUSH_BACK, 32'sh7fff_ffff, 4'd0);
        send_request(REQ_PUSH_FRONT, -32'sd1, 4'd0);
        send_request(REQ_PUSH_BACK, 32'sd0, 4'd0);
        send_request(REQ_REMOVE, 32'sd0, 4'd15);
        send_request(REQ_REMOVE, 32'sd0, 4'd4);
        send_request(REQ_REMOVE, 32'sd0, 4'd1);
        send_request(REQ_REMOVE, 32'sd0, 4'd2);
        send_request(REQ_REMOVE, 32'sd0, 4'd0);
        send_request(t_req_type'(7), 32'sh5555_aaaa, 4'd9);
        send_request(t_req_type'(5), 32'sd3, 4'd6);
        for (n = 0; n < DEPTH - 1; n++)
            send_request(REQ_PUSH_BACK, t_value'($urandom), 4'd0);
        send_request(REQ_PUSH_FRONT, 32'sd11, 4'd0);
        send_request(REQ_PUSH_BACK, 32'sd12, 4'd0);
        send_request(REQ_REMOVE, 32'sd0, 4'd7);

        mood = 2;
        for (n = 0; n < RANDOM_REQS; n++) begin
            if (n % PHASE_LEN == 0) begin
                mood = $urandom_range(0, 2);
                calm = ($urandom_range(0, 3) == 0);
            end
            send_random(mood);
        end
        i_in_valid = 1'b0;
        calm       = 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
